// File: design/lebe_pkg.sv
`timescale 1ns / 1ps

package lebe_pkg;

  localparam int LINE_DEPTH_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int OP_W     = 4;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 9;
  localparam int QPOS_W   = 7;

  localparam logic [CHAR_W-1:0] CR_BYTE = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_OVERWRITE  = 4'd0,
    OP_DELETE     = 4'd1,
    OP_INSERT     = 4'd2,
    OP_BACKSPACE  = 4'd3,
    OP_WIPE_RIGHT = 4'd4,
    OP_WIPE_ALL   = 4'd5,
    OP_CLEAR      = 4'd6,
    OP_TRIM_CR    = 4'd7,
    OP_ENQUEUE    = 4'd8,
    OP_DEQUEUE    = 4'd9,
    OP_ADVANCE    = 4'd10,
    OP_READ       = 4'd11
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_in;
    logic [COUNT_W-1:0] count;
    logic               flag;
    logic [INDEX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    cursor_pos;
    logic [POS_W-1:0]    line_len;
    logic [QPOS_W-1:0]   queue_len;
    logic [QPOS_W-1:0]   queue_pos;
    logic [CHAR_W-1:0]   read_byte;
    logic                line_changed;
  } out_item_t;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [5:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_LOAD,
    ACT_ST1,
    ACT_ST2,
    ACT_DEL_SET,
    ACT_INS_SET,
    ACT_BKSP,
    ACT_CLR_SET,
    ACT_ENQ,
    ACT_MV_INIT,
    ACT_QD_INIT,
    ACT_RD_ISSUE,
    ACT_RD_CAP,
    ACT_LREAD_PTR,
    ACT_PTR_INC,
    ACT_PTR_DEC,
    ACT_PUT_WR,
    ACT_QREAD,
    ACT_SD_RD,
    ACT_SD_WR,
    ACT_SD_END,
    ACT_SU_RD,
    ACT_SU_WR,
    ACT_FILL,
    ACT_INS_END,
    ACT_NC_NF,
    ACT_NC_F,
    ACT_WR_SET,
    ACT_LREAD_PM1,
    ACT_WA_SET,
    ACT_WA_SET_M1,
    ACT_TR_READ,
    ACT_TR_CUT,
    ACT_QD_RD,
    ACT_QD_WR,
    ACT_QD_END,
    ACT_OUT
  } act_t;

  typedef struct packed {
    act_t act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic flag;
    logic is_move;
    logic put_skip;
    logic ptr_full;
    logic lrd_cr;
    logic ptr_at_len;
    logic ptr_at_cur;
    logic ptr_zero;
    logic fill_done;
    logic trim_go;
    logic qptr_at_n;
    logic qptr_at_qlen;
    logic del_oob;
    logic ins_full;
    logic deq_oob;
    logic rd_oob;
    logic clr_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/lebe_ram.sv
`timescale 1ns / 1ps

module lebe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lebe_ctrl.sv
`timescale 1ns / 1ps

module lebe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lebe_pkg::dp_stat_t  stat,
  output lebe_pkg::ctrl_cmd_t cmd
);

  import lebe_pkg::*;

  typedef enum logic [24:0] {
    S_INIT    = 25'h0000001,
    S_IDLE    = 25'h0000002,
    S_DISP    = 25'h0000004,
    S_PUT_RD  = 25'h0000008,
    S_PUT_CHK = 25'h0000010,
    S_PUT_WR  = 25'h0000020,
    S_MV_Q    = 25'h0000040,
    S_SD_RD   = 25'h0000080,
    S_SD_WR   = 25'h0000100,
    S_SD_END  = 25'h0000200,
    S_SU_RD   = 25'h0000400,
    S_SU_WR   = 25'h0000800,
    S_FILL    = 25'h0001000,
    S_NC_RD   = 25'h0002000,
    S_NC_CHK  = 25'h0004000,
    S_NC_END  = 25'h0008000,
    S_PC_RD   = 25'h0010000,
    S_PC_CHK  = 25'h0020000,
    S_TR_RD   = 25'h0040000,
    S_TR_CHK  = 25'h0080000,
    S_QD_RD   = 25'h0100000,
    S_QD_WR   = 25'h0200000,
    S_QD_END  = 25'h0400000,
    S_RD_WAIT = 25'h0800000,
    S_DONE    = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.act   = ACT_NONE;
    unique case (state_r)
      S_INIT: begin
        if (stat.clr_done) state_nxt = S_IDLE;
        else cmd.act = ACT_CLR;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op) inside
          OP_OVERWRITE: state_nxt = S_PUT_RD;
          OP_DELETE: begin
            if (stat.del_oob) begin
              cmd.act   = ACT_ST1;
              state_nxt = S_DONE;
            end else begin
              cmd.act   = ACT_DEL_SET;
              state_nxt = S_SD_RD;
            end
          end
          OP_INSERT: begin
            if (stat.ins_full) begin
              cmd.act   = ACT_ST2;
              state_nxt = S_DONE;
            end else begin
              cmd.act   = ACT_INS_SET;
              state_nxt = S_SU_RD;
            end
          end
          OP_BACKSPACE: begin
            cmd.act   = ACT_BKSP;
            state_nxt = S_DONE;
          end
          OP_WIPE_RIGHT, OP_WIPE_ALL: state_nxt = S_NC_RD;
          OP_CLEAR: begin
            cmd.act   = ACT_CLR_SET;
            state_nxt = S_SD_RD;
          end
          OP_TRIM_CR: state_nxt = S_TR_RD;
          OP_ENQUEUE: begin
            cmd.act   = ACT_ENQ;
            state_nxt = S_DONE;
          end
          OP_DEQUEUE, OP_ADVANCE: begin
            if (stat.deq_oob) begin
              cmd.act   = ACT_ST1;
              state_nxt = S_DONE;
            end else if (stat.flag) begin
              cmd.act   = ACT_MV_INIT;
              state_nxt = S_MV_Q;
            end else begin
              cmd.act   = ACT_QD_INIT;
              state_nxt = S_QD_RD;
            end
          end
          OP_READ: begin
            if (stat.rd_oob) begin
              cmd.act   = ACT_ST1;
              state_nxt = S_DONE;
            end else begin
              cmd.act   = ACT_RD_ISSUE;
              state_nxt = S_RD_WAIT;
            end
          end
          default: begin
            cmd.act   = ACT_ST1;
            state_nxt = S_DONE;
          end
        endcase
      end
      // Write one byte at the cursor (the input byte, or a queue byte for a move), optionally stepping over stored CRs.
      S_PUT_RD: begin
        if (stat.ptr_full) begin
          cmd.act   = ACT_ST2;
          state_nxt = S_DONE;
        end else if (stat.put_skip) begin
          cmd.act   = ACT_LREAD_PTR;
          state_nxt = S_PUT_CHK;
        end else begin
          state_nxt = S_PUT_WR;
        end
      end
      S_PUT_CHK: begin
        if (stat.lrd_cr) begin
          cmd.act   = ACT_PTR_INC;
          state_nxt = S_PUT_RD;
        end else begin
          state_nxt = S_PUT_WR;
        end
      end
      S_PUT_WR: begin
        cmd.act   = ACT_PUT_WR;
        state_nxt = stat.is_move ? S_MV_Q : S_DONE;
      end
      S_MV_Q: begin
        if (stat.qptr_at_n) begin
          cmd.act   = ACT_QD_INIT;
          state_nxt = S_QD_RD;
        end else begin
          cmd.act   = ACT_QREAD;
          state_nxt = S_PUT_RD;
        end
      end
      // Shift the line down over a gap, zero filling the vacated tail.
      S_SD_RD: begin
        if (stat.ptr_at_len) begin
          state_nxt = S_SD_END;
        end else begin
          cmd.act   = ACT_SD_RD;
          state_nxt = S_SD_WR;
        end
      end
      S_SD_WR: begin
        cmd.act   = ACT_SD_WR;
        state_nxt = S_SD_RD;
      end
      S_SD_END: begin
        cmd.act   = ACT_SD_END;
        state_nxt = S_DONE;
      end
      // Shift the line up from the top, then fill the opened gap.
      S_SU_RD: begin
        if (stat.ptr_at_cur) begin
          state_nxt = S_FILL;
        end else begin
          cmd.act   = ACT_SU_RD;
          state_nxt = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.act   = ACT_SU_WR;
        state_nxt = S_SU_RD;
      end
      S_FILL: begin
        if (stat.fill_done) begin
          cmd.act   = ACT_INS_END;
          state_nxt = S_DONE;
        end else begin
          cmd.act = ACT_FILL;
        end
      end
      S_NC_RD: begin
        if (stat.ptr_at_len) begin
          cmd.act   = ACT_NC_NF;
          state_nxt = S_NC_END;
        end else begin
          cmd.act   = ACT_LREAD_PTR;
          state_nxt = S_NC_CHK;
        end
      end
      S_NC_CHK: begin
        if (stat.lrd_cr) begin
          cmd.act   = ACT_NC_F;
          state_nxt = S_NC_END;
        end else begin
          cmd.act   = ACT_PTR_INC;
          state_nxt = S_NC_RD;
        end
      end
      S_NC_END: begin
        if (stat.op == OP_WIPE_RIGHT) begin
          cmd.act   = ACT_WR_SET;
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_PC_RD;
        end
      end
      S_PC_RD: begin
        if (stat.ptr_zero) begin
          cmd.act   = ACT_WA_SET;
          state_nxt = S_SD_RD;
        end else begin
          cmd.act   = ACT_LREAD_PM1;
          state_nxt = S_PC_CHK;
        end
      end
      S_PC_CHK: begin
        if (stat.lrd_cr) begin
          cmd.act   = ACT_WA_SET_M1;
          state_nxt = S_SD_RD;
        end else begin
          cmd.act   = ACT_PTR_DEC;
          state_nxt = S_PC_RD;
        end
      end
      S_TR_RD: begin
        if (stat.trim_go) begin
          cmd.act   = ACT_TR_READ;
          state_nxt = S_TR_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TR_CHK: begin
        if (stat.lrd_cr) begin
          cmd.act   = ACT_TR_CUT;
          state_nxt = S_TR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_QD_RD: begin
        if (stat.qptr_at_qlen) begin
          state_nxt = S_QD_END;
        end else begin
          cmd.act   = ACT_QD_RD;
          state_nxt = S_QD_WR;
        end
      end
      S_QD_WR: begin
        cmd.act   = ACT_QD_WR;
        state_nxt = S_QD_RD;
      end
      S_QD_END: begin
        cmd.act   = ACT_QD_END;
        state_nxt = S_DONE;
      end
      S_RD_WAIT: begin
        cmd.act   = ACT_RD_CAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.act   = ACT_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// File: design/lebe_dp.sv
`timescale 1ns / 1ps

module lebe_dp #(
  parameter int LINE_DEPTH  = 256,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lebe_pkg::ctrl_cmd_t cmd,
  output lebe_pkg::dp_stat_t  stat,
  input  lebe_pkg::in_item_t  in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output lebe_pkg::out_item_t out_item
);

  import lebe_pkg::*;

  localparam int LW  = $clog2(LINE_DEPTH + 1);
  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int QW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int MW  = (LW > QW) ? LW : QW;
  localparam int CW  = ((MW > COUNT_W) ? MW : COUNT_W) + 1;
  localparam logic [LW-1:0] LD_L = LW'(LINE_DEPTH);
  localparam logic [QW-1:0] QD_Q = QW'(QUEUE_DEPTH);

  in_item_t item_r, item_nxt;
  logic [LW-1:0] cur_r, cur_nxt, len_r, len_nxt, ptr_r, ptr_nxt;
  logic [LW-1:0] amt_r, amt_nxt, rpos_r, rpos_nxt;
  logic found_r, found_nxt;
  logic [QW-1:0] qlen_r, qlen_nxt, qmark_r, qmark_nxt, qptr_r, qptr_nxt, qamt_r, qamt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic changed_r, changed_nxt;
  logic [CHAR_W-1:0] rd_r, rd_nxt;
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic l_we, l_re, q_we, q_re;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [CHAR_W-1:0] l_wdata, l_rdata, q_wdata, q_rdata;

  logic [LW:0] src_w;
  logic sd_in;
  logic [LW-1:0] ptr_m1;
  logic [QW:0] qsrc_w;
  logic qd_in;
  logic is_move;
  logic [COUNT_W-1:0] n_eff;
  logic [CW-1:0] cur_c, len_c, cnt_c, neff_c, qlen_c, qmark_c, idx_c;

  lebe_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  lebe_ram #(.WIDTH(CHAR_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  assign is_move = (item_r.op == OP_DEQUEUE) || (item_r.op == OP_ADVANCE);
  assign n_eff   = (item_r.op == OP_ADVANCE) ? COUNT_W'(1) : item_r.count;
  assign src_w   = {1'b0, ptr_r} + {1'b0, amt_r};
  assign sd_in   = src_w < {1'b0, len_r};
  assign ptr_m1  = ptr_r - LW'(1);
  assign qsrc_w  = {1'b0, qptr_r} + {1'b0, qamt_r};
  assign qd_in   = qsrc_w < {1'b0, qlen_r};

  assign cur_c   = CW'(cur_r);
  assign len_c   = CW'(len_r);
  assign cnt_c   = CW'(item_r.count);
  assign neff_c  = CW'(n_eff);
  assign qlen_c  = CW'(qlen_r);
  assign qmark_c = CW'(qmark_r);
  assign idx_c   = CW'(item_r.index);

  always_comb begin
    stat.op           = item_r.op;
    stat.flag         = item_r.flag;
    stat.is_move      = is_move;
    stat.put_skip     = is_move || item_r.flag;
    stat.ptr_full     = (ptr_r == LD_L);
    stat.lrd_cr       = (l_rdata == CR_BYTE);
    stat.ptr_at_len   = (ptr_r == len_r);
    stat.ptr_at_cur   = (ptr_r == cur_r);
    stat.ptr_zero     = (ptr_r == '0);
    stat.fill_done    = ({1'b0, ptr_r} == ({1'b0, cur_r} + {1'b0, amt_r}));
    stat.trim_go      = (len_r != '0) && ((cur_c + CW'(1)) < len_c);
    stat.qptr_at_n    = (CW'(qptr_r) == neff_c);
    stat.qptr_at_qlen = (qptr_r == qlen_r);
    stat.del_oob      = (cur_c + cnt_c) > len_c;
    stat.ins_full     = (len_c + cnt_c) > CW'(LINE_DEPTH);
    stat.deq_oob      = neff_c > qlen_c;
    stat.rd_oob       = item_r.flag ? (idx_c >= CW'(QUEUE_DEPTH)) :
                                      (idx_c >= CW'(LINE_DEPTH));
    stat.clr_done     = (ptr_r == LD_L) && (qptr_r == QD_Q);
    stat.out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    amt_nxt       = amt_r;
    rpos_nxt      = rpos_r;
    found_nxt     = found_r;
    qlen_nxt      = qlen_r;
    qmark_nxt     = qmark_r;
    qptr_nxt      = qptr_r;
    qamt_nxt      = qamt_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    rd_nxt        = rd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    l_we = 1'b0; l_waddr = ptr_r[LAW-1:0]; l_wdata = '0;
    l_re = 1'b0; l_raddr = ptr_r[LAW-1:0];
    q_we = 1'b0; q_waddr = qptr_r[QAW-1:0]; q_wdata = '0;
    q_re = 1'b0; q_raddr = qptr_r[QAW-1:0];

    unique case (cmd.act)
      ACT_CLR: begin
        if (ptr_r != LD_L) begin
          l_we    = 1'b1;
          ptr_nxt = ptr_r + LW'(1);
        end
        if (qptr_r != QD_Q) begin
          q_we     = 1'b1;
          qptr_nxt = qptr_r + QW'(1);
        end
      end
      ACT_LOAD: begin
        item_nxt    = in_item;
        status_nxt  = ST_OK;
        changed_nxt = 1'b0;
        rd_nxt      = '0;
        ptr_nxt     = cur_r;
        qptr_nxt    = '0;
      end
      ACT_ST1: status_nxt = ST_RANGE;
      ACT_ST2: status_nxt = ST_FULL;
      ACT_DEL_SET: begin
        amt_nxt     = LW'(item_r.count);
        ptr_nxt     = cur_r;
        changed_nxt = 1'b1;
      end
      ACT_INS_SET: begin
        amt_nxt     = LW'(item_r.count);
        ptr_nxt     = len_r;
        changed_nxt = 1'b1;
      end
      ACT_BKSP: begin
        if (cnt_c > cur_c) begin
          cur_nxt    = '0;
          status_nxt = ST_RANGE;
        end else begin
          cur_nxt = cur_r - LW'(item_r.count);
        end
      end
      ACT_CLR_SET: begin
        amt_nxt = len_r;
        ptr_nxt = '0;
        cur_nxt = '0;
      end
      ACT_ENQ: begin
        if (qlen_r == QD_Q) begin
          status_nxt = ST_FULL;
        end else begin
          q_we      = 1'b1;
          q_waddr   = qlen_r[QAW-1:0];
          q_wdata   = item_r.char_in;
          qlen_nxt  = qlen_r + QW'(1);
          qmark_nxt = qmark_r + QW'(1);
          if ((qlen_r + QW'(1)) == QD_Q) status_nxt = ST_FULL;
        end
      end
      ACT_MV_INIT: changed_nxt = 1'b1;
      ACT_QD_INIT: begin
        qptr_nxt = '0;
        qamt_nxt = QW'(n_eff);
      end
      ACT_RD_ISSUE: begin
        if (item_r.flag) begin
          q_re    = 1'b1;
          q_raddr = QAW'(item_r.index);
        end else begin
          l_re    = 1'b1;
          l_raddr = LAW'(item_r.index);
        end
      end
      ACT_RD_CAP: rd_nxt = item_r.flag ? q_rdata : l_rdata;
      ACT_LREAD_PTR: l_re = 1'b1;
      ACT_PTR_INC: ptr_nxt = ptr_r + LW'(1);
      ACT_PTR_DEC: ptr_nxt = ptr_m1;
      ACT_PUT_WR: begin
        l_we        = 1'b1;
        l_wdata     = is_move ? q_rdata : item_r.char_in;
        if (ptr_r == len_r) len_nxt = len_r + LW'(1);
        cur_nxt     = ptr_r + LW'(1);
        ptr_nxt     = ptr_r + LW'(1);
        qptr_nxt    = qptr_r + QW'(1);
        changed_nxt = 1'b1;
      end
      ACT_QREAD: q_re = 1'b1;
      ACT_SD_RD: begin
        l_re    = sd_in;
        l_raddr = src_w[LAW-1:0];
      end
      ACT_SD_WR: begin
        l_we    = 1'b1;
        l_wdata = sd_in ? l_rdata : '0;
        ptr_nxt = ptr_r + LW'(1);
      end
      ACT_SD_END: len_nxt = len_r - amt_r;
      ACT_SU_RD: begin
        l_re    = 1'b1;
        l_raddr = ptr_m1[LAW-1:0];
      end
      ACT_SU_WR: begin
        l_we    = 1'b1;
        l_waddr = LAW'(ptr_m1 + amt_r);
        l_wdata = l_rdata;
        ptr_nxt = ptr_m1;
      end
      ACT_FILL: begin
        l_we    = 1'b1;
        l_wdata = item_r.char_in;
        ptr_nxt = ptr_r + LW'(1);
      end
      ACT_INS_END: len_nxt = len_r + amt_r;
      ACT_NC_NF: begin
        rpos_nxt  = len_r;
        found_nxt = 1'b0;
        ptr_nxt   = cur_r;
      end
      ACT_NC_F: begin
        rpos_nxt  = ptr_r;
        found_nxt = 1'b1;
        ptr_nxt   = cur_r;
      end
      ACT_WR_SET: begin
        // A wipe from the line start also takes the CR that ends the segment.
        amt_nxt     = rpos_r - cur_r + LW'(found_r && (cur_r == '0));
        ptr_nxt     = cur_r;
        changed_nxt = 1'b1;
      end
      ACT_LREAD_PM1: begin
        l_re    = 1'b1;
        l_raddr = ptr_m1[LAW-1:0];
      end
      ACT_WA_SET: begin
        cur_nxt     = ptr_r;
        amt_nxt     = rpos_r - ptr_r;
        changed_nxt = 1'b1;
      end
      ACT_WA_SET_M1: begin
        cur_nxt     = ptr_m1;
        amt_nxt     = rpos_r - ptr_m1;
        ptr_nxt     = ptr_m1;
        changed_nxt = 1'b1;
      end
      ACT_TR_READ: begin
        l_re    = 1'b1;
        l_raddr = LAW'(len_r - LW'(1));
      end
      ACT_TR_CUT: begin
        l_we        = 1'b1;
        l_waddr     = LAW'(len_r - LW'(1));
        len_nxt     = len_r - LW'(1);
        changed_nxt = 1'b1;
      end
      ACT_QD_RD: begin
        q_re    = qd_in;
        q_raddr = qsrc_w[QAW-1:0];
      end
      ACT_QD_WR: begin
        q_we     = 1'b1;
        q_wdata  = qd_in ? q_rdata : '0;
        qptr_nxt = qptr_r + QW'(1);
      end
      ACT_QD_END: begin
        qlen_nxt = qlen_r - qamt_r;
        if (item_r.op == OP_ADVANCE) begin
          qmark_nxt = QW'((qlen_r - qamt_r) != '0);
        end else if (neff_c > qmark_c) begin
          qmark_nxt  = '0;
          status_nxt = ST_RANGE;
        end else begin
          qmark_nxt = qmark_r - qamt_r;
        end
      end
      ACT_OUT: begin
        out_nxt.status       = status_r;
        out_nxt.cursor_pos   = POS_W'(cur_r);
        out_nxt.line_len     = POS_W'(len_r);
        out_nxt.queue_len    = QPOS_W'(qlen_r);
        out_nxt.queue_pos    = QPOS_W'(qmark_r);
        out_nxt.read_byte    = rd_r;
        out_nxt.line_changed = changed_r;
        out_valid_nxt        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      len_r       <= '0;
      ptr_r       <= '0;
      qlen_r      <= '0;
      qmark_r     <= '0;
      qptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      qlen_r      <= qlen_nxt;
      qmark_r     <= qmark_nxt;
      qptr_r      <= qptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    amt_r     <= amt_nxt;
    rpos_r    <= rpos_nxt;
    found_r   <= found_nxt;
    qamt_r    <= qamt_nxt;
    status_r  <= status_nxt;
    changed_r <= changed_nxt;
    rd_r      <= rd_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: design/line_edit_buffer_engine_unit.sv
`timescale 1ns / 1ps

// Command-line edit engine: a line store with cursor and length plus a small
// pending-byte queue, both in single-port-write RAMs with registered reads.
// One edit transaction is worked on at a time. Simple operations (backspace,
// enqueue, refused delete, insert and dequeue, unused op codes) go from
// dispatch straight to the result; read waits for its registered RAM read,
// and a refused overwrite may first step over stored CRs. Every move of
// bytes passes each byte through one read and one write of the line or
// queue RAM: delete and the wipes walk from the cursor (or segment start)
// to the line end, insert moves the tail up and then fills count bytes,
// CR searches read byte by byte, and dequeue walks the whole queue. After
// reset both stores are swept to zero, one entry per cycle, before the
// first transaction is taken. A finished result sits in an output register,
// so the next transaction can be accepted while it waits.
module line_edit_buffer_engine_unit #(
  parameter int LINE_DEPTH  = lebe_pkg::LINE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = lebe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lebe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lebe_pkg::out_item_t out_item
);

  import lebe_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lebe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lebe_dp #(
    .LINE_DEPTH (LINE_DEPTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_item (out_item)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.cursor_pos <= out_item.line_len))
    else $error("cursor beyond line end");

  a_marker_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.queue_pos <= out_item.queue_len))
    else $error("queue marker beyond queue length");
`endif

endmodule
